### rtl/core/arm_data_processing_execute_core_macros.svh
// Assertion helpers; expect i_clk and i_rst_n in scope.
`ifndef ARM_DATA_PROCESSING_EXECUTE_CORE_MACROS_SVH
`define ARM_DATA_PROCESSING_EXECUTE_CORE_MACROS_SVH

`define ADPE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("adpe: same-cycle check failed");

`define ADPE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("adpe: next-cycle check failed");

`endif

### rtl/core/adpe_pkg.sv
package adpe_pkg;

    localparam logic [1:0] ST_EXEC  = 2'd0;
    localparam logic [1:0] ST_SKIP  = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;

    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_RSB = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_TST = 4'd8;
    localparam logic [3:0] OP_TEQ = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MOV = 4'd13;

    localparam logic [3:0] COND_EQ = 4'd0;
    localparam logic [3:0] COND_NE = 4'd1;
    localparam logic [3:0] COND_CS = 4'd2;
    localparam logic [3:0] COND_CC = 4'd3;
    localparam logic [3:0] COND_MI = 4'd4;
    localparam logic [3:0] COND_PL = 4'd5;
    localparam logic [3:0] COND_VS = 4'd6;
    localparam logic [3:0] COND_VC = 4'd7;
    localparam logic [3:0] COND_HI = 4'd8;
    localparam logic [3:0] COND_LS = 4'd9;
    localparam logic [3:0] COND_GE = 4'd10;
    localparam logic [3:0] COND_LT = 4'd11;
    localparam logic [3:0] COND_GT = 4'd12;
    localparam logic [3:0] COND_LE = 4'd13;
    localparam logic [3:0] COND_AL = 4'd14;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;

    function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] t;
        t = {v, v} >> n;
        return t[31:0];
    endfunction

    // flags: {N, Z, C, V}
    function automatic logic cond_pass(input logic [3:0] cond, input logic [3:0] f);
        logic r;
        case (cond)
            COND_EQ: r = f[2];
            COND_NE: r = !f[2];
            COND_CS: r = f[1];
            COND_CC: r = !f[1];
            COND_MI: r = f[3];
            COND_PL: r = !f[3];
            COND_VS: r = f[0];
            COND_VC: r = !f[0];
            COND_HI: r = f[1] && !f[2];
            COND_LS: r = !f[1] || f[2];
            COND_GE: r = (f[3] == f[0]);
            COND_LT: r = (f[3] != f[0]);
            COND_GT: r = !f[2] && (f[3] == f[0]);
            COND_LE: r = f[2] || (f[3] != f[0]);
            COND_AL: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_unsup(input logic [3:0] opc);
        return !(opc == OP_AND || opc == OP_EOR || opc == OP_SUB || opc == OP_RSB ||
                 opc == OP_ADD || opc == OP_TST || opc == OP_TEQ || opc == OP_CMP ||
                 opc == OP_ORR || opc == OP_MOV);
    endfunction

    // returns {carry, value}
    function automatic logic [32:0] shift_op(input logic [1:0] typ, input logic [31:0] v,
                                             input logic [7:0] amt, input logic by_reg,
                                             input logic cin);
        logic [4:0]  a5;
        logic        big;
        logic [31:0] sa;
        logic [32:0] r;
        a5  = amt[4:0];
        big = |amt[7:5];
        sa  = $unsigned($signed(v) >>> a5);
        r   = {cin, v};
        if (amt == 8'd0) begin
            if (!by_reg) begin
                case (typ)
                    SH_LSL:  r = {cin, v};
                    SH_LSR:  r = {v[31], 32'd0};
                    SH_ASR:  r = {v[31], {32{v[31]}}};
                    default: r = {v[0], cin, v[31:1]};
                endcase
            end
        end else begin
            case (typ)
                SH_LSL: begin
                    if (big) begin
                        r = {(amt == 8'd32) ? v[0] : 1'b0, 32'd0};
                    end else begin
                        r = {v[5'd0 - a5], v << a5};
                    end
                end
                SH_LSR: begin
                    if (big) begin
                        r = {(amt == 8'd32) ? v[31] : 1'b0, 32'd0};
                    end else begin
                        r = {v[a5 - 5'd1], v >> a5};
                    end
                end
                SH_ASR: begin
                    if (big) begin
                        r = {v[31], {32{v[31]}}};
                    end else begin
                        r = {v[a5 - 5'd1], sa};
                    end
                end
                default: begin
                    if (a5 == 5'd0) begin
                        r = {v[31], v};
                    end else begin
                        r = {v[a5 - 5'd1], ror32(v, a5)};
                    end
                end
            endcase
        end
        return r;
    endfunction

endpackage

### rtl/core/adpe_if.sv
interface adpe_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

interface adpe_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        wrote_register;
    logic [3:0]  dest_index;
    logic [31:0] result_value;
    logic [3:0]  flags_nzcv;

    modport source (output valid, output status, output wrote_register, output dest_index,
                    output result_value, output flags_nzcv, input ready);
    modport sink   (input valid, input status, input wrote_register, input dest_index,
                    input result_value, input flags_nzcv, output ready);
endinterface

### rtl/core/arm_data_processing_execute_core.sv
// Operands register on input word accept, then execute registers the result word.
// Throughput: one word per cycle back to back when the output is ready, including
// dependent instructions; reads are forwarded from the write of the one ahead.
// Register file: two mirrored sync-read 16x32 memories (Rn/Rm and Rs ports).
// Reset: per-entry valid bits clear so every register reads as zero; NZCV clears.
`include "arm_data_processing_execute_core_macros.svh"

module arm_data_processing_execute_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    adpe_in_if.sink           i_in,
    adpe_out_if.source        o_out
);

    logic [31:0] r_mem_a [16];
    logic [31:0] r_mem_b [16];
    logic [15:0] r_vld;

    logic        r_s1_valid;
    logic [31:0] r_s1_ins;
    logic [31:0] r_rn;
    logic [31:0] r_rm;
    logic [31:0] r_rs;
    logic [3:0]  r_flags;

    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic        r_out_wrote;
    logic [3:0]  r_out_dest;
    logic [31:0] r_out_result;
    logic [3:0]  r_out_flags;

    logic        w_s1_adv;
    logic        w_in_acc;
    logic [3:0]  rn_a;
    logic [3:0]  rm_a;
    logic [3:0]  rs_a;

    logic [3:0]  opc;
    logic        pass;
    logic        unsup;
    logic        exec;
    logic [4:0]  rot;
    logic [31:0] op2;
    logic        shc;
    logic [32:0] sh;
    logic        is_sub;
    logic        is_rsb;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic [32:0] sum;
    logic [31:0] res;
    logic        res_c;
    logic        writes;
    logic [1:0]  n_status;
    logic [3:0]  n_flags;

    logic        w_wr_en;
    logic [3:0]  w_wr_addr;

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_s1_adv;
    assign w_in_acc   = i_in.valid && i_in.ready;

    assign rn_a = i_in.instruction_word[19:16];
    assign rm_a = i_in.instruction_word[3:0];
    assign rs_a = i_in.instruction_word[11:8];

    // execute
    always_comb begin
        opc   = r_s1_ins[24:21];
        pass  = adpe_pkg::cond_pass(r_s1_ins[31:28], r_flags);
        unsup = adpe_pkg::is_unsup(opc);
        exec  = pass && !unsup;

        rot = {r_s1_ins[11:8], 1'b0};
        sh  = adpe_pkg::shift_op(r_s1_ins[6:5], r_rm,
                                 r_s1_ins[4] ? r_rs[7:0] : {3'd0, r_s1_ins[11:7]},
                                 r_s1_ins[4], r_flags[1]);
        if (r_s1_ins[25]) begin
            op2 = adpe_pkg::ror32({24'd0, r_s1_ins[7:0]}, rot);
            shc = (rot != 5'd0) ? op2[31] : r_flags[1];
        end else begin
            op2 = sh[31:0];
            shc = sh[32];
        end

        is_sub = (opc == adpe_pkg::OP_SUB) || (opc == adpe_pkg::OP_CMP);
        is_rsb = (opc == adpe_pkg::OP_RSB);
        add_a  = is_rsb ? op2 : r_rn;
        add_b  = is_rsb ? ~r_rn : (is_sub ? ~op2 : op2);
        sum    = {1'b0, add_a} + {1'b0, add_b} + {32'd0, is_sub || is_rsb};

        res   = op2;
        res_c = shc;
        case (opc)
            adpe_pkg::OP_AND, adpe_pkg::OP_TST: res = r_rn & op2;
            adpe_pkg::OP_EOR, adpe_pkg::OP_TEQ: res = r_rn ^ op2;
            adpe_pkg::OP_ORR:                   res = r_rn | op2;
            adpe_pkg::OP_SUB, adpe_pkg::OP_CMP, adpe_pkg::OP_RSB, adpe_pkg::OP_ADD: begin
                res   = sum[31:0];
                res_c = sum[32];
            end
            default: res = op2;
        endcase

        writes = exec && (opc != adpe_pkg::OP_TST) && (opc != adpe_pkg::OP_TEQ)
                      && (opc != adpe_pkg::OP_CMP);

        if (exec && r_s1_ins[20]) begin
            n_flags = {res[31], res == 32'd0, res_c, r_flags[0]};
        end else begin
            n_flags = r_flags;
        end

        if (!pass) begin
            n_status = adpe_pkg::ST_SKIP;
        end else if (unsup) begin
            n_status = adpe_pkg::ST_UNSUP;
        end else begin
            n_status = adpe_pkg::ST_EXEC;
        end
    end

    assign w_wr_en   = w_s1_adv && writes;
    assign w_wr_addr = r_s1_ins[15:12];

    // register file
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem_a[w_wr_addr] <= res;
            r_mem_b[w_wr_addr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_wr_en) begin
            r_vld[w_wr_addr] <= 1'b1;
        end
    end

    // reads, forwarded from the write retiring on the same edge
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_ins <= i_in.instruction_word;
            if (w_wr_en && w_wr_addr == rn_a) begin
                r_rn <= res;
            end else if (r_vld[rn_a]) begin
                r_rn <= r_mem_a[rn_a];
            end else begin
                r_rn <= '0;
            end
            if (w_wr_en && w_wr_addr == rm_a) begin
                r_rm <= res;
            end else if (r_vld[rm_a]) begin
                r_rm <= r_mem_a[rm_a];
            end else begin
                r_rm <= '0;
            end
            if (w_wr_en && w_wr_addr == rs_a) begin
                r_rs <= res;
            end else if (r_vld[rs_a]) begin
                r_rs <= r_mem_b[rs_a];
            end else begin
                r_rs <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_status <= n_status;
            r_out_wrote  <= writes;
            r_out_dest   <= r_s1_ins[15:12];
            r_out_result <= exec ? res : 32'd0;
            r_out_flags  <= n_flags;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.wrote_register = r_out_wrote;
    assign o_out.dest_index     = r_out_dest;
    assign o_out.result_value   = r_out_result;
    assign o_out.flags_nzcv     = r_out_flags;

    `ADPE_ASSERT_IMP(a_no_overrun, w_in_acc && r_s1_valid, w_s1_adv)
    `ADPE_ASSERT_NXT(a_hold_result, r_out_valid && !o_out.ready, r_out_valid)
    `ADPE_ASSERT_NXT(a_flags_kept, w_s1_adv && n_status != adpe_pkg::ST_EXEC, r_flags == $past(r_flags))

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 20;
    localparam int WORDS_PER_PHASE = 370;
    localparam int MAX_REPORTS = 10;

    localparam logic [3:0] COND_NV = 4'd15;
    localparam logic [1:0] SH_ROR = 2'd3;
    localparam logic [3:0] OP_ADC = 4'd5;
    localparam logic [3:0] OP_MVN = 4'd15;

    typedef struct packed {
        logic [1:0]  status;
        logic        wrote;
        logic [3:0]  rd;
        logic [31:0] value;
        logic [3:0]  nzcv;
    } t_retire;

    logic i_clk;
    logic i_rst_n;

    adpe_in_if  in_bus ();
    adpe_out_if out_bus ();

    arm_data_processing_execute_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    logic [31:0] instr_q [$];
    t_retire     retire_q [$];

    logic [31:0] arch_regs [16];
    logic [3:0]  arch_nzcv;

    int src_idle_pct;
    int sink_stall_pct;
    int hold_req;
    int hold_ack;
    int hold_left;
    int stall_run;
    logic in_took;

    int n_words;
    int n_exec;
    int n_skip;
    int n_unsup;
    int n_results;
    int mismatches;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        int unsigned k;
        k = n % 32;
        if (k == 0) return v;
        return (v >> k) | (v << (32 - k));
    endfunction

    function automatic logic cond_holds(input logic [3:0] cc, input logic [3:0] f);
        logic n, z, c, v;
        {n, z, c, v} = f;
        case (cc)
            adpe_pkg::COND_EQ: return z;
            adpe_pkg::COND_NE: return !z;
            adpe_pkg::COND_CS: return c;
            adpe_pkg::COND_CC: return !c;
            adpe_pkg::COND_MI: return n;
            adpe_pkg::COND_PL: return !n;
            adpe_pkg::COND_VS: return v;
            adpe_pkg::COND_VC: return !v;
            adpe_pkg::COND_HI: return c && !z;
            adpe_pkg::COND_LS: return !c || z;
            adpe_pkg::COND_GE: return n == v;
            adpe_pkg::COND_LT: return n != v;
            adpe_pkg::COND_GT: return !z && (n == v);
            adpe_pkg::COND_LE: return z || (n != v);
            adpe_pkg::COND_AL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // returns {carry, value}
    function automatic logic [32:0] shift_operand(input logic [1:0] kind, input logic [31:0] v,
                                                  input logic [7:0] amt, input logic by_reg,
                                                  input logic cin);
        logic [63:0]        wide;
        logic signed [63:0] swide;
        logic [31:0]        rr;
        int unsigned        n;
        n = amt;
        if (!by_reg && n == 0) begin
            case (kind)
                adpe_pkg::SH_LSL: return {cin, v};
                SH_ROR: return {v[0], cin, v[31:1]};
                default: n = 32;
            endcase
        end
        if (n == 0) return {cin, v};
        case (kind)
            adpe_pkg::SH_LSL: begin
                wide = {32'd0, v} << n;
                return {wide[32], wide[31:0]};
            end
            adpe_pkg::SH_LSR: begin
                wide = {v, 32'd0} >> n;
                return {wide[31], wide[63:32]};
            end
            adpe_pkg::SH_ASR: begin
                swide = {v, 32'd0};
                swide = swide >>> ((n > 32) ? 32 : n);
                return {swide[31], swide[63:32]};
            end
            default: begin
                rr = rotr(v, n);
                return {rr[31], rr};
            end
        endcase
    endfunction

    function automatic t_retire execute_instr(input logic [31:0] w);
        t_retire     r;
        logic [3:0]  opc;
        logic [31:0] rn_val;
        logic [31:0] op2;
        logic [31:0] res;
        logic        cy;
        logic        known;
        int unsigned rot;
        opc = w[24:21];
        rn_val = arch_regs[w[19:16]];
        cy = arch_nzcv[1];
        res = '0;
        r.status = adpe_pkg::ST_EXEC;
        r.wrote = 1'b0;
        r.rd = w[15:12];
        case (opc)
            adpe_pkg::OP_AND, adpe_pkg::OP_EOR, adpe_pkg::OP_SUB, adpe_pkg::OP_RSB,
            adpe_pkg::OP_ADD, adpe_pkg::OP_TST, adpe_pkg::OP_TEQ, adpe_pkg::OP_CMP,
            adpe_pkg::OP_ORR, adpe_pkg::OP_MOV: known = 1'b1;
            default: known = 1'b0;
        endcase
        if (!cond_holds(w[31:28], arch_nzcv)) begin
            r.status = adpe_pkg::ST_SKIP;
            n_skip++;
        end else if (!known) begin
            r.status = adpe_pkg::ST_UNSUP;
            n_unsup++;
        end else begin
            n_exec++;
            if (w[25]) begin
                rot = 2 * w[11:8];
                op2 = rotr({24'd0, w[7:0]}, rot);
                if (rot != 0) cy = op2[31];
            end else if (w[4]) begin
                {cy, op2} = shift_operand(w[6:5], arch_regs[w[3:0]], arch_regs[w[11:8]][7:0],
                                         1'b1, cy);
            end else begin
                {cy, op2} = shift_operand(w[6:5], arch_regs[w[3:0]], {3'd0, w[11:7]}, 1'b0, cy);
            end
            case (opc)
                adpe_pkg::OP_AND, adpe_pkg::OP_TST: res = rn_val & op2;
                adpe_pkg::OP_EOR, adpe_pkg::OP_TEQ: res = rn_val ^ op2;
                adpe_pkg::OP_SUB, adpe_pkg::OP_CMP: begin
                    res = rn_val - op2;
                    cy = rn_val >= op2;
                end
                adpe_pkg::OP_RSB: begin
                    res = op2 - rn_val;
                    cy = op2 >= rn_val;
                end
                adpe_pkg::OP_ADD: {cy, res} = {1'b0, rn_val} + {1'b0, op2};
                adpe_pkg::OP_ORR: res = rn_val | op2;
                default: res = op2;
            endcase
            if (w[20]) arch_nzcv = {res[31], res == 32'd0, cy, arch_nzcv[0]};
            if (opc != adpe_pkg::OP_TST && opc != adpe_pkg::OP_TEQ &&
                opc != adpe_pkg::OP_CMP) begin
                arch_regs[w[15:12]] = res;
                r.wrote = 1'b1;
            end
        end
        r.value = res;
        r.nzcv = arch_nzcv;
        return r;
    endfunction

    function automatic logic [31:0] dp_word(input logic [3:0] cond, input logic imm,
                                            input logic [3:0] opc, input logic s,
                                            input logic [3:0] rn, input logic [3:0] rd,
                                            input logic [11:0] op2);
        return {cond, 2'b00, imm, opc, s, rn, rd, op2};
    endfunction

    function automatic logic [3:0] pick_op(input int unsigned k);
        case (k)
            0: return adpe_pkg::OP_AND;
            1: return adpe_pkg::OP_EOR;
            2: return adpe_pkg::OP_SUB;
            3: return adpe_pkg::OP_RSB;
            4: return adpe_pkg::OP_ADD;
            5: return adpe_pkg::OP_TST;
            6: return adpe_pkg::OP_TEQ;
            7: return adpe_pkg::OP_CMP;
            8: return adpe_pkg::OP_ORR;
            default: return adpe_pkg::OP_MOV;
        endcase
    endfunction

    // mostly decodable words; MOV #small plants shift amounts for register shifts
    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        int unsigned pick;
        w = $urandom();
        pick = $urandom_range(99);
        if (pick < 20) begin
            w[31:28] = adpe_pkg::COND_AL;
            w[25] = 1'b1;
            w[24:21] = adpe_pkg::OP_MOV;
            if ($urandom_range(3) != 0) w[11:8] = 4'd0;
        end else if (pick < 85) begin
            if ($urandom_range(3) != 0) w[31:28] = adpe_pkg::COND_AL;
            w[24:21] = pick_op($urandom_range(9));
        end
        return w;
    endfunction

    function automatic string retire_str(input t_retire r);
        return $sformatf("status=%0d wrote=%0d rd=%0d value=%h nzcv=%b",
                         r.status, r.wrote, r.rd, r.value, r.nzcv);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_took) begin
            if (instr_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                in_bus.valid <= 1'b1;
                in_bus.instruction_word <= instr_q.pop_front();
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_ack != hold_req) begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_retire got;
        t_retire want;
        in_took = 1'b0;
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready) begin
                in_took = 1'b1;
                n_words++;
                retire_q.push_back(execute_instr(in_bus.instruction_word));
            end
            if (out_bus.valid && out_bus.ready) begin
                got.status = out_bus.status;
                got.wrote = out_bus.wrote_register;
                got.rd = out_bus.dest_index;
                got.value = out_bus.result_value;
                got.nzcv = out_bus.flags_nzcv;
                n_results++;
                if (retire_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result word with none expected: %s", $realtime,
                                 retire_str(got));
                end else begin
                    want = retire_q.pop_front();
                    if (got.status !== want.status || got.wrote !== want.wrote ||
                        got.rd !== want.rd || got.value !== want.value ||
                        got.nzcv !== want.nzcv) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: mismatch\n  exp %s\n  got %s", $realtime,
                                     retire_str(want), retire_str(got));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            stall_run <= 0;
        end else if (stall_run >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            stall_run <= stall_run + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.instruction_word = '0;
        out_bus.ready = 1'b0;
        in_took = 1'b0;
        arch_nzcv = '0;
        foreach (arch_regs[i]) arch_regs[i] = '0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_req = 0;
        hold_ack = 0;
        hold_left = 0;
        stall_run = 0;
        n_words = 0;
        n_exec = 0;
        n_skip = 0;
        n_unsup = 0;
        n_results = 0;
        mismatches = 0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 5; ph++) begin
            @(posedge i_clk);
            case (ph)
                1: begin src_idle_pct = 50; sink_stall_pct = 0; end
                2: begin src_idle_pct = 0; sink_stall_pct = 50; end
                3: begin src_idle_pct = 24; sink_stall_pct = 24; end
                default: begin src_idle_pct = 0; sink_stall_pct = 0; end
            endcase
            if (ph == 0) begin
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b1, adpe_pkg::OP_MOV, 1'b1,
                                          4'd0, 4'd1, 12'h0FF));
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b1, adpe_pkg::OP_MOV, 1'b1,
                                          4'd0, 4'd2, 12'h1FF));
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b1, adpe_pkg::OP_MOV, 1'b0,
                                          4'd0, 4'd3, 12'h020));
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b1, adpe_pkg::OP_MOV, 1'b0,
                                          4'd0, 4'd4, 12'h021));
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b1, adpe_pkg::OP_MOV, 1'b1,
                                          4'd0, 4'd5, 12'h000));
                // Z set: NE fails, also with a bad opcode
                instr_q.push_back(dp_word(adpe_pkg::COND_NE, 1'b1, adpe_pkg::OP_MOV, 1'b1,
                                          4'd0, 4'd6, 12'h001));
                instr_q.push_back(dp_word(adpe_pkg::COND_NE, 1'b0, OP_ADC, 1'b1,
                                          4'd1, 4'd6, 12'h002));
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b0, OP_MVN, 1'b1,
                                          4'd1, 4'd6, 12'h002));
                instr_q.push_back(dp_word(COND_NV, 1'b1, adpe_pkg::OP_MOV, 1'b1,
                                          4'd0, 4'd6, 12'h001));
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_ADD, 1'b1,
                                          4'd2, 4'd6, 12'h002));
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_SUB, 1'b1,
                                          4'd1, 4'd7, 12'h002));
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_RSB, 1'b1,
                                          4'd1, 4'd8, 12'h002));
                // LSR #0, ASR #0, RRX
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_AND, 1'b1,
                                          4'd2, 4'd9, 12'h021));
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_EOR, 1'b1,
                                          4'd1, 4'd10, 12'h042));
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_ORR, 1'b1,
                                          4'd5, 4'd11, 12'h062));
                // register shifts by 32, 33, 0 and 255
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_MOV, 1'b1,
                                          4'd7, 4'd12, 12'h312));
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_MOV, 1'b1,
                                          4'd0, 4'd12, 12'h432));
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_MOV, 1'b1,
                                          4'd0, 4'd12, 12'h452));
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_MOV, 1'b1,
                                          4'd0, 4'd12, 12'h372));
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_MOV, 1'b1,
                                          4'd0, 4'd12, 12'h512));
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_MOV, 1'b1,
                                          4'd0, 4'd13, 12'h1F2));
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_MOV, 1'b1,
                                          4'd0, 4'd14, 12'h082));
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_TST, 1'b1,
                                          4'd1, 4'd0, 12'h002));
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_TEQ, 1'b1,
                                          4'd1, 4'd0, 12'h001));
                instr_q.push_back(dp_word(adpe_pkg::COND_AL, 1'b0, adpe_pkg::OP_CMP, 1'b1,
                                          4'd2, 4'd0, 12'h001));
            end
            if (ph == 4) hold_req++;
            repeat (WORDS_PER_PHASE) instr_q.push_back(rand_word());
            while (instr_q.size() != 0 || in_bus.valid) @(posedge i_clk);
            while (retire_q.size() != 0) @(posedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d instruction words: %0d executed, %0d condition-skipped, %0d unsupported,",
                 n_words, n_exec, n_skip, n_unsup);
        $display("over five idle/stall phases incl. a long output hold; %0d results, %0d bad.",
                 n_results, mismatches);
        if (mismatches == 0 && retire_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
